// ----- src/rv32alu_pkg.sv -----
// Package for the RV32I R-type execute unit.
// Holds widths, opcode and function codes, and the ALU result type.
// No dependencies.
package rv32alu_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned NREG   = 32;
  localparam int unsigned REG_AW = 5;

  localparam logic [6:0] OPCODE_OP = 7'h33;
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SRL  = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } f3_t;

  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            invalid;
  } alu_res_t;

endpackage

// ----- src/rv32alu_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module rv32alu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- src/rv32alu_alu.sv -----
// Decoder and ALU for one R-type instruction word.
// Depends on rv32alu_pkg.
module rv32alu_alu
  import rv32alu_pkg::*;
(
  input  logic [XLEN-1:0] instr,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  output alu_res_t        res
);

  logic [6:0]        opcode;
  logic [6:0]        funct7;
  f3_t               funct3;
  logic              alt;
  logic [REG_AW-1:0] sh;

  assign opcode = instr[6:0];
  assign funct3 = f3_t'(instr[14:12]);
  assign funct7 = instr[31:25];
  assign alt    = (funct7 == F7_ALT);
  assign sh     = op_b[REG_AW-1:0];

  always_comb begin
    res.invalid = (opcode != OPCODE_OP) ||
                  (((funct3 == F3_ADD) || (funct3 == F3_SRL)) &&
                   (funct7 != F7_BASE) && (funct7 != F7_ALT));
    case (funct3)
      F3_ADD:  res.value = alt ? (op_a - op_b) : (op_a + op_b);
      F3_SLL:  res.value = op_a << sh;
      F3_SLT:  res.value = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
      F3_SLTU: res.value = {{(XLEN-1){1'b0}}, (op_a < op_b)};
      F3_XOR:  res.value = op_a ^ op_b;
      F3_SRL:  res.value = alt ? XLEN'($signed(op_a) >>> sh) : (op_a >> sh);
      F3_OR:   res.value = op_a | op_b;
      default: res.value = op_a & op_b;
    endcase
  end

endmodule

// ----- src/rv32_rtype_alu_execute_unit.sv -----
// Top level of the RV32I R-type execute unit with its own register file.
// Depends on rv32alu_pkg, rv32alu_ram and rv32alu_alu.
//
// Channel | Direction | tdata (low bit up)                          | tuser
// in_     | slave     | instr_word[31:0] load_index[36:32]          | cmd
//         |           | load_value[68:37], zero pad to 72 bits      |
// out_    | master    | dest_index[4:0] dest_value[36:5], pad to 40 | wrote, invalid
//
// One transfer is taken every cycle unless the output stalls.
// The register file read is the first stage and the ALU plus write-back the second.
// A write in the second stage is forwarded to the item read in the same cycle.
// Reset clears the register file through per-entry valid bits at once.
// A stalled output register holds the second stage, which then holds the input.
module rv32_rtype_alu_execute_unit
  import rv32alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // instr_word, load_index, load_value
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // dest_index, dest_value
  output logic [1:0]  out_tuser   // wrote, invalid
);

  logic              in_fire;
  logic              s1_adv;
  logic [REG_AW-1:0] in_rs1;
  logic [REG_AW-1:0] in_rs2;

  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [XLEN-1:0]   s1_instr_r;
  logic [REG_AW-1:0] s1_lidx_r;
  logic [XLEN-1:0]   s1_lval_r;
  logic              s1_v1_r;
  logic              s1_v2_r;

  logic [NREG-1:0]   valid_r;
  logic              fwd_vld_r;
  logic [REG_AW-1:0] fwd_idx_r;
  logic [XLEN-1:0]   fwd_data_r;

  logic [XLEN-1:0]   rd1;
  logic [XLEN-1:0]   rd2;
  logic [REG_AW-1:0] rs1;
  logic [REG_AW-1:0] rs2;
  logic [XLEN-1:0]   op_a;
  logic [XLEN-1:0]   op_b;
  alu_res_t          alu_res;

  logic              s1_load;
  logic              s1_bad;
  logic [REG_AW-1:0] wb_idx;
  logic [XLEN-1:0]   wb_val;
  logic              wb_en;

  logic              out_valid_r;
  logic [REG_AW-1:0] out_idx_r;
  logic [XLEN-1:0]   out_val_r;
  logic              out_wrote_r;
  logic              out_inv_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign in_rs1    = in_tdata[19:15];
  assign in_rs2    = in_tdata[24:20];

  assign rs1 = s1_instr_r[19:15];
  assign rs2 = s1_instr_r[24:20];

  always_comb begin
    if (rs1 == '0) begin
      op_a = '0;
    end else if (fwd_vld_r && (fwd_idx_r == rs1)) begin
      op_a = fwd_data_r;
    end else begin
      op_a = s1_v1_r ? rd1 : '0;
    end
    if (rs2 == '0) begin
      op_b = '0;
    end else if (fwd_vld_r && (fwd_idx_r == rs2)) begin
      op_b = fwd_data_r;
    end else begin
      op_b = s1_v2_r ? rd2 : '0;
    end
  end

  rv32alu_alu u_alu (
    .instr (s1_instr_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (alu_res)
  );

  assign s1_load = (s1_cmd_r == CMD_LOAD);
  assign s1_bad  = !s1_load && alu_res.invalid;
  assign wb_idx  = s1_bad ? '0 : (s1_load ? s1_lidx_r : s1_instr_r[11:7]);
  assign wb_val  = (s1_bad || (wb_idx == '0)) ? '0 :
                   (s1_load ? s1_lval_r : alu_res.value);
  assign wb_en   = s1_adv && !s1_bad && (wb_idx != '0);

  rv32alu_ram #(
    .WIDTH (XLEN),
    .DEPTH (NREG)
  ) u_regfile (
    .clk     (clk),
    .we      (wb_en),
    .waddr   (wb_idx),
    .wdata   (wb_val),
    .re      (in_fire),
    .raddr_a (in_rs1),
    .raddr_b (in_rs2),
    .rdata_a (rd1),
    .rdata_b (rd2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      valid_r     <= '0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wb_en) begin
        valid_r[wb_idx] <= 1'b1;
        fwd_vld_r       <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_tuser[0];
      s1_instr_r <= in_tdata[31:0];
      s1_lidx_r  <= in_tdata[36:32];
      s1_lval_r  <= in_tdata[68:37];
      s1_v1_r    <= valid_r[in_rs1];
      s1_v2_r    <= valid_r[in_rs2];
    end
    if (wb_en) begin
      fwd_idx_r  <= wb_idx;
      fwd_data_r <= wb_val;
    end
    if (s1_adv) begin
      out_idx_r   <= wb_idx;
      out_val_r   <= wb_val;
      out_wrote_r <= !s1_bad;
      out_inv_r   <= s1_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_idx_r};
  assign out_tuser  = {out_inv_r, out_wrote_r};

endmodule

// ----- src/rv32alu_checker.sv -----
// Port-level checker for the RV32I R-type execute unit, bound to the top level.
// Depends on rv32_rtype_alu_execute_unit.
module rv32alu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid straight after reset.");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] != out_tuser[1]))
    else $error("Result must be either a write or a rejection.");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 40'd0))
    else $error("Rejected word must report zero index and value.");

  a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[4:0] == 5'd0)) |-> (out_tdata[36:5] == 32'd0))
    else $error("Register zero must report a zero value.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled result changed.");

endmodule

bind rv32_rtype_alu_execute_unit rv32alu_checker u_chk (.*);

// ----- sim/tb.sv -----
// Self-checking testbench for rv32_rtype_alu_execute_unit: R-type execute and load
// transfers with random idling and a long output stall. Results are checked against
// a local register file model. Depends on rv32alu_pkg and the unit's RTL.
module tb
  import rv32alu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_OPS  = 1100;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
    logic [4:0]  lidx;
    logic [31:0] lval;
  } op_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] val;
    logic        wrote;
    logic        invalid;
  } wb_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  op_t         issue_q[$];
  wb_t         writeback_q[$];
  op_t         cur_op = '0;
  logic [31:0] reg_file[NREG];
  int unsigned cyc = 0;
  int unsigned rx_cnt = 0;
  int unsigned errors = 0;

  rv32_rtype_alu_execute_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rtype(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        f3_t f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPCODE_OP};
  endfunction

  function automatic wb_t execute_op(op_t op);
    wb_t         r;
    f3_t         f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
    logic [4:0]  idx;
    logic [31:0] v;
    r = '0;
    if (op.cmd == CMD_LOAD) begin
      idx = op.lidx;
      v   = op.lval;
    end else begin
      f3 = f3_t'(op.word[14:12]);
      f7 = op.word[31:25];
      if (op.word[6:0] != OPCODE_OP ||
          ((f3 == F3_ADD || f3 == F3_SRL) && f7 != F7_BASE && f7 != F7_ALT)) begin
        r.invalid = 1'b1;
        return r;
      end
      idx = op.word[11:7];
      a   = reg_file[op.word[19:15]];
      b   = reg_file[op.word[24:20]];
      sh  = b[4:0];
      case (f3)
        F3_ADD:  v = (f7 == F7_ALT) ? a - b : a + b;
        F3_SLL:  v = a << sh;
        F3_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        F3_SLTU: v = (a < b) ? 32'd1 : 32'd0;
        F3_XOR:  v = a ^ b;
        F3_SRL:  v = (f7 == F7_ALT) ? $unsigned($signed(a) >>> sh) : a >> sh;
        F3_OR:   v = a | b;
        default: v = a & b;
      endcase
    end
    if (idx == '0) v = '0;
    reg_file[idx] = v;
    r.idx   = idx;
    r.val   = v;
    r.wrote = 1'b1;
    return r;
  endfunction

  task automatic queue_op(logic cmd, logic [31:0] word, logic [4:0] lidx, logic [31:0] lval);
    op_t op;
    op.cmd  = cmd;
    op.word = word;
    op.lidx = lidx;
    op.lval = lval;
    issue_q.push_back(op);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  function automatic bit idle_now();
    if (cyc >= 1000 && cyc < 1400) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // Driver: predicts each accepted transfer, then offers the next op.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) writeback_q.push_back(execute_op(cur_op));
      if (issue_q.size() != 0 && !idle_now()) begin
        cur_op    = issue_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, cur_op.lval, cur_op.lidx, cur_op.word};
        in_tuser  <= cur_op.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each output transfer with the oldest predicted write-back.
  always @(posedge clk) begin
    wb_t exp_wb;
    if (rst_n) begin
      rx_cnt <= rx_cnt + 1;
      if (out_tvalid && out_tready) begin
        if (writeback_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          exp_wb = writeback_q.pop_front();
          check_field("dest_index", 32'(exp_wb.idx), 32'(out_tdata[4:0]));
          check_field("dest_value", exp_wb.val, out_tdata[36:5]);
          check_field("wrote", 32'(exp_wb.wrote), 32'(out_tuser[0]));
          check_field("invalid", 32'(exp_wb.invalid), 32'(out_tuser[1]));
        end
      end
      if (rx_cnt >= 600 && rx_cnt < 800) out_tready <= 1'b0;
      else                               out_tready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    logic [31:0] v;
    logic [6:0]  f7;
    int unsigned pick;

    foreach (reg_file[i]) reg_file[i] = '0;

    queue_op(CMD_LOAD, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    queue_op(CMD_LOAD, 32'h0000_0000, 5'd1, 32'h8000_0000);
    queue_op(CMD_LOAD, '0, 5'd2, 32'h7fff_ffff);
    queue_op(CMD_LOAD, '0, 5'd0, 32'hdead_beef);
    queue_op(CMD_LOAD, '0, 5'd3, 32'h0000_0004);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd31, F3_ADD, 5'd4), '1, '1);
    queue_op(CMD_EXEC, rtype(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd5), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd31, 5'd31, F3_SLL, 5'd6), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd7), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd8), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd31, F3_XOR, 5'd9), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd3, 5'd1, F3_SRL, 5'd10), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_ALT, 5'd3, 5'd1, F3_SRL, 5'd11), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_ALT, 5'd31, 5'd1, F3_SRL, 5'd12), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd1, F3_OR, 5'd13), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd31, F3_AND, 5'd14), '0, '0);
    queue_op(CMD_EXEC, rtype(F7_BASE, 5'd2, 5'd31, F3_ADD, 5'd0), '0, '0);
    queue_op(CMD_EXEC, rtype(7'h7f, 5'd2, 5'd1, F3_XOR, 5'd15), '0, '0);
    queue_op(CMD_EXEC, rtype(7'h01, 5'd2, 5'd1, F3_ADD, 5'd16), '0, '0);
    queue_op(CMD_EXEC, rtype(7'h7f, 5'd2, 5'd1, F3_SRL, 5'd17), '0, '0);
    queue_op(CMD_EXEC, {rtype(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd18)} ^ 32'h0000_0010, '0, '0);
    queue_op(CMD_EXEC, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    queue_op(CMD_EXEC, 32'h0000_0000, '0, '0);
    queue_op(CMD_EXEC, rtype(F7_ALT, 5'd0, 5'd0, F3_ADD, 5'd19), '0, '0);

    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 7))
          0:       v = 32'h0000_0000;
          1:       v = 32'hffff_ffff;
          2:       v = 32'h8000_0000;
          3:       v = 32'h7fff_ffff;
          4:       v = $urandom_range(0, 40);
          default: v = $urandom;
        endcase
        queue_op(CMD_LOAD, $urandom, 5'($urandom_range(0, 31)), v);
      end else if (pick < 33) begin
        queue_op(CMD_EXEC, $urandom, 5'($urandom_range(0, 31)), $urandom);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: f7 = F7_BASE;
          4, 5, 6, 7: f7 = F7_ALT;
          default:    f7 = 7'($urandom_range(0, 127));
        endcase
        w = rtype(f7, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  f3_t'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 19) == 0) w[6:0] = 7'($urandom_range(0, 127));
        queue_op(CMD_EXEC, w, 5'($urandom_range(0, 31)), $urandom);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (issue_q.size() != 0 || in_tvalid || writeback_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) $display("tb: done, clean");
    else             $display("tb: done, errors");
    $finish;
  end

endmodule
